>>> hw/rtl/mmp_pkg.sv
`timescale 1ns / 1ps

package mmp_pkg;

	localparam int ENTRY_W   = 30;
	localparam int POW_W     = 31;
	localparam int EXP_BITS  = 31;
	localparam int PROD_W    = 2 * ENTRY_W;
	localparam int S_TDATA_W = 152;
	localparam int M_TDATA_W = 120;

	localparam logic [ENTRY_W-1:0] PRIME_MOD = 30'd998244353;

	// Barrett constant floor(2^60 / p), 31 bits wide
	localparam logic [63:0] MU_WIDE    = (64'd1 << PROD_W) / 64'd998244353;
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	// issue to writeback, in cycles
	localparam int PIPE_LAT = 5;
	localparam int WAIT_CYC = PIPE_LAT - 1;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		entry_t m11;
		entry_t m10;
		entry_t m01;
		entry_t m00;
	} mat_t;

	typedef struct packed {
		logic load;
		logic issue_mul;
		logic issue_sqr;
		logic out_load;
	} mmp_cmd_t;

endpackage

>>> hw/rtl/mmp_modmul.sv
`timescale 1ns / 1ps

module mmp_modmul
	import mmp_pkg::*;
(
	input  logic   clk,
	input  entry_t a,
	input  entry_t b,
	output entry_t r
);

	localparam logic [31:0] P32  = {2'b00, PRIME_MOD};
	localparam logic [31:0] P2X  = P32 << 1;

	logic [PROD_W-1:0] prod_s1;
	logic [61:0]       q2_s2;
	logic [31:0]       low_s2;
	logic [31:0]       t_s3;
	logic [31:0]       low_s3;
	entry_t            r_s4;

	logic [60:0] t_full;
	logic [31:0] diff;
	logic [31:0] red;

	assign t_full = 61'(q2_s2[61:31]) * 61'(PRIME_MOD);
	assign diff   = low_s3 - t_s3;

	// Barrett leaves diff below 3p
	always_comb begin
		if (diff >= P2X) begin
			red = diff - P2X;
		end else if (diff >= P32) begin
			red = diff - P32;
		end else begin
			red = diff;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
		q2_s2   <= 62'(prod_s1[PROD_W-1:29]) * 62'(BARRETT_MU);
		low_s2  <= prod_s1[31:0];
		t_s3    <= t_full[31:0];
		low_s3  <= low_s2;
		r_s4    <= red[ENTRY_W-1:0];
	end

	assign r = r_s4;

endmodule

>>> hw/rtl/mmp_datapath.sv
`timescale 1ns / 1ps

module mmp_datapath
	import mmp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mmp_cmd_t         cmd,
	input  mat_t             in_mat,
	input  logic [POW_W-1:0] power,
	output mat_t             res
);

	function automatic entry_t fold_entry(input entry_t x);
		entry_t y;
		y = (x >= PRIME_MOD) ? x - PRIME_MOD : x;
		return y;
	endfunction

	function automatic entry_t mod_add(input entry_t x, input entry_t y);
		logic [ENTRY_W:0] s;
		logic [ENTRY_W:0] pm;
		pm = {1'b0, PRIME_MOD};
		s  = {1'b0, x} + {1'b0, y};
		if (s >= pm) begin
			s = s - pm;
		end
		return s[ENTRY_W-1:0];
	endfunction

	mat_t             base_q;
	mat_t             acc_q;
	mat_t             res_q;
	logic [POW_W-1:0] exp_q;

	logic tag_vld_s1, tag_vld_s2, tag_vld_s3, tag_vld_s4;
	logic tag_sqr_s1, tag_sqr_s2, tag_sqr_s3, tag_sqr_s4;

	mat_t   lhs;
	mat_t   sum_m;
	entry_t mul_a [8];
	entry_t mul_b [8];
	entry_t prod  [8];

	assign lhs = cmd.issue_sqr ? base_q : acc_q;

	always_comb begin
		mul_a[0] = lhs.m00; mul_b[0] = base_q.m00;
		mul_a[1] = lhs.m01; mul_b[1] = base_q.m10;
		mul_a[2] = lhs.m00; mul_b[2] = base_q.m01;
		mul_a[3] = lhs.m01; mul_b[3] = base_q.m11;
		mul_a[4] = lhs.m10; mul_b[4] = base_q.m00;
		mul_a[5] = lhs.m11; mul_b[5] = base_q.m10;
		mul_a[6] = lhs.m10; mul_b[6] = base_q.m01;
		mul_a[7] = lhs.m11; mul_b[7] = base_q.m11;
	end

	for (genvar i = 0; i < 8; i++) begin : g_lane
		mmp_modmul u_mul (
			.clk (clk),
			.a   (mul_a[i]),
			.b   (mul_b[i]),
			.r   (prod[i])
		);
	end

	always_comb begin
		sum_m.m00 = mod_add(prod[0], prod[1]);
		sum_m.m01 = mod_add(prod[2], prod[3]);
		sum_m.m10 = mod_add(prod[4], prod[5]);
		sum_m.m11 = mod_add(prod[6], prod[7]);
	end

	// multiply request is dropped when the exponent bit is clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_s1 <= 1'b0;
			tag_vld_s2 <= 1'b0;
			tag_vld_s3 <= 1'b0;
			tag_vld_s4 <= 1'b0;
		end else begin
			tag_vld_s1 <= cmd.issue_sqr | (cmd.issue_mul & exp_q[0]);
			tag_vld_s2 <= tag_vld_s1;
			tag_vld_s3 <= tag_vld_s2;
			tag_vld_s4 <= tag_vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_sqr_s1 <= cmd.issue_sqr;
		tag_sqr_s2 <= tag_sqr_s1;
		tag_sqr_s3 <= tag_sqr_s2;
		tag_sqr_s4 <= tag_sqr_s3;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q.m00 <= fold_entry(in_mat.m00);
			base_q.m01 <= fold_entry(in_mat.m01);
			base_q.m10 <= fold_entry(in_mat.m10);
			base_q.m11 <= fold_entry(in_mat.m11);
			acc_q.m00  <= entry_t'(1);
			acc_q.m01  <= '0;
			acc_q.m10  <= '0;
			acc_q.m11  <= entry_t'(1);
			exp_q      <= power;
		end else begin
			if (tag_vld_s4) begin
				if (tag_sqr_s4) begin
					base_q <= sum_m;
				end else begin
					acc_q <= sum_m;
				end
			end
			if (cmd.issue_sqr) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.out_load) begin
			res_q <= acc_q;
		end
	end

	assign res = res_q;

endmodule

>>> hw/rtl/mmp_ctrl.sv
`timescale 1ns / 1ps

module mmp_ctrl
	import mmp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output mmp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int CNT_W  = $clog2(EXP_BITS) + 1;
	localparam int WAIT_W = $clog2(WAIT_CYC) + 1;

	localparam logic [CNT_W-1:0]  LAST_BIT  = CNT_W'(EXP_BITS - 1);
	localparam logic [WAIT_W-1:0] LAST_WAIT = WAIT_W'(WAIT_CYC - 1);

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  bit_q;
	logic [WAIT_W-1:0] wait_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.issue_mul = (state_q == ST_MUL);
		cmd.issue_sqr = (state_q == ST_SQR);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bit_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					wait_q  <= '0;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// new base lands on the last wait edge
					if (wait_q == LAST_WAIT) begin
						if (bit_q == LAST_BIT) begin
							state_q <= ST_DONE;
						end else begin
							bit_q   <= bit_q + 1'b1;
							state_q <= ST_MUL;
						end
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/mod_matrix_power_2x2.sv
`timescale 1ns / 1ps
// Handles one request at a time: a new request is accepted only in idle, once the
// previous result is loaded into the output register. Each of the 31 exponent bits
// issues a multiply and a square to the Barrett modular multiply pipeline (8 lanes).
// Reset (arst_n, async, active low) clears the controller and valid flags;
// matrix and exponent registers are not reset.
module mod_matrix_power_2x2
	import mmp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_00, entry_01, entry_10, entry_11, power, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// result_00, result_01, result_10, result_11
	output logic [M_TDATA_W-1:0] m_tdata
);

	mmp_cmd_t         cmd;
	mat_t             in_mat;
	mat_t             res;
	logic [POW_W-1:0] power;

	assign in_mat.m00 = s_tdata[29:0];
	assign in_mat.m01 = s_tdata[59:30];
	assign in_mat.m10 = s_tdata[89:60];
	assign in_mat.m11 = s_tdata[119:90];
	assign power      = s_tdata[150:120];

	assign m_tdata = {res.m11, res.m10, res.m01, res.m00};

	mmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	mmp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.in_mat (in_mat),
		.power  (power),
		.res    (res)
	);

endmodule

>>> bench/mmp_checker.sv
`timescale 1ns / 1ps

module mmp_checker
	import mmp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// entry_00, entry_01, entry_10, entry_11, power, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// result_00, result_01, result_10, result_11
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   fails,
	output int                   pending
);

	mat_t expected_powers[$];

	initial begin
		fails   = 0;
		pending = 0;
	end

	// operands are below the prime, so the product fits in 60 bits
	function automatic entry_t mulmod(entry_t x, entry_t y);
		logic [63:0] w;
		w = 64'(x) * 64'(y);
		return entry_t'(w % 64'(PRIME_MOD));
	endfunction

	function automatic entry_t addmod(entry_t x, entry_t y);
		logic [31:0] s;
		s = 32'(x) + 32'(y);
		return entry_t'(s % 32'(PRIME_MOD));
	endfunction

	function automatic mat_t matmul(mat_t a, mat_t b);
		mat_t r;
		r.m00 = addmod(mulmod(a.m00, b.m00), mulmod(a.m01, b.m10));
		r.m01 = addmod(mulmod(a.m00, b.m01), mulmod(a.m01, b.m11));
		r.m10 = addmod(mulmod(a.m10, b.m00), mulmod(a.m11, b.m10));
		r.m11 = addmod(mulmod(a.m10, b.m01), mulmod(a.m11, b.m11));
		return r;
	endfunction

	// square-and-multiply, low exponent bit first; raw entries reduced first
	function automatic mat_t matrix_power(mat_t raw, logic [POW_W-1:0] pw);
		mat_t acc;
		mat_t sq;
		sq.m00  = entry_t'(raw.m00 % PRIME_MOD);
		sq.m01  = entry_t'(raw.m01 % PRIME_MOD);
		sq.m10  = entry_t'(raw.m10 % PRIME_MOD);
		sq.m11  = entry_t'(raw.m11 % PRIME_MOD);
		acc.m00 = entry_t'(1);
		acc.m01 = '0;
		acc.m10 = '0;
		acc.m11 = entry_t'(1);
		for (int b = 0; b < EXP_BITS; b++) begin
			if (pw[b])
				acc = matmul(acc, sq);
			sq = matmul(sq, sq);
		end
		return acc;
	endfunction

	task automatic check_field(string name, entry_t exp_v, entry_t got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		mat_t got;
		mat_t exp_m;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = mat_t'(m_tdata);
				if (expected_powers.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fails++;
				end else begin
					exp_m = expected_powers.pop_front();
					check_field("result_00", exp_m.m00, got.m00);
					check_field("result_01", exp_m.m01, got.m01);
					check_field("result_10", exp_m.m10, got.m10);
					check_field("result_11", exp_m.m11, got.m11);
				end
			end
			if (s_tvalid && s_tready)
				expected_powers.push_back(matrix_power(mat_t'(s_tdata[4*ENTRY_W-1:0]),
					s_tdata[4*ENTRY_W +: POW_W]));
			pending = expected_powers.size();
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import mmp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int N_RANDOM    = 1580;
	localparam int HOLD_CYC    = 700;
	localparam int DRAIN_CYC   = 200;

	localparam entry_t PRIME_M1 = entry_t'(PRIME_MOD - 30'd1);
	localparam entry_t PRIME_M2 = entry_t'(PRIME_MOD - 30'd2);
	localparam entry_t PRIME_P1 = entry_t'(PRIME_MOD + 30'd1);

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	int                   fails;
	int                   pending;
	int                   quiet_cycles = 0;
	bit                   calm = 1'b0;
	bit                   rx_hold_req = 1'b0;

	always #5 clk = ~clk;

	mod_matrix_power_2x2 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mmp_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.fails    (fails),
		.pending  (pending)
	);

	function automatic mat_t mk(entry_t a, entry_t b, entry_t c, entry_t d);
		mat_t m;
		m.m00 = a;
		m.m01 = b;
		m.m10 = c;
		m.m11 = d;
		return m;
	endfunction

	// mostly proper residues, sometimes any 30-bit pattern
	function automatic entry_t rand_entry();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return PRIME_MOD - entry_t'($urandom_range(1, 0));
		else if (r < 85)
			return entry_t'($urandom_range(PRIME_MOD - 1, 0));
		else
			return entry_t'($urandom());
	endfunction

	function automatic logic [POW_W-1:0] rand_power();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return POW_W'($urandom_range(40, 0));
		else if (r < 45)
			return POW_W'(1) << $urandom_range(POW_W - 1, 0);
		else
			return POW_W'($urandom());
	endfunction

	// one request: optional gap, then hold valid until accepted
	task automatic offer(mat_t m, logic [POW_W-1:0] pw);
		int unsigned gap;
		if (!calm && $urandom_range(99) < 10) begin
			gap = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 1) : $urandom_range(8, 1);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, pw, m};
		do @(posedge clk); while (!s_tready);
	endtask

	// result side: random back-pressure plus one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 10);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: identity cases, reduction of unreduced entries, extremes
		offer(mk(0, 0, 0, 0), 0);
		offer(mk(0, 0, 0, 0), 1);
		offer(mk(5, 7, 11, 13), 0);
		offer(mk(1, 1, 1, 0), 10);
		offer(mk(1, 1, 1, 0), 31'h7FFFFFFF);
		offer(mk(1, 0, 0, 1), 31'h7FFFFFFF);
		offer(mk(PRIME_M1, PRIME_M1, PRIME_M1, PRIME_M1), 1);
		offer(mk(PRIME_M1, PRIME_M1, PRIME_M1, PRIME_M1), 31'h7FFFFFFF);
		offer(mk(PRIME_MOD, PRIME_MOD, PRIME_MOD, PRIME_MOD), 3);
		offer(mk(PRIME_P1, PRIME_P1, PRIME_P1, PRIME_P1), 5);
		offer(mk(30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF), 1);
		offer(mk(30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF), 31'h7FFFFFFF);
		offer(mk(2, 0, 0, 3), 31'h40000000);
		offer(mk(0, 1, PRIME_M1, 0), 4);
		offer(mk(12345, PRIME_M2, 67890, 30'h3FFFFFFF), 31'h55555555);
		offer(mk(1, 2, 3, 4), 31'h2AAAAAAA);
		offer(mk(0, 0, 1, 0), 2);
		offer(mk(PRIME_M1, 0, 0, 1), 31'h40000001);
		offer(mk(30'h2AAAAAAA, 30'h15555555, 30'h0, 30'h3FFFFFFF), 31'h7FFFFFFE);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				rx_hold_req = 1'b1;
			if (i == 600) begin
				// drain fully before going on
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (pending == 0);
			end
			calm = (i >= 900 && i < 1100);
			offer(mk(rand_entry(), rand_entry(), rand_entry(), rand_entry()), rand_power());
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
